@@ rtl/core/brb_pkg.sv @@
// ----------------------------------------------------------------------------
// brb_pkg
// Shared types, constants and helpers for the byte ring buffer with overwrite.
// ----------------------------------------------------------------------------
`default_nettype none

package brb_pkg;

  // Ring geometry: RING_SIZE must be a power of two between 4 and 128
  localparam int RING_SIZE   = 64;
  localparam int PTR_W       = $clog2(RING_SIZE);
  localparam int CNT_W       = 7;                 // count / length / fill width
  localparam int MAX_LEN     = RING_SIZE - 1;     // most bytes ever held
  localparam int MAX_RESULTS = 64;                // cap on bytes per extract
  localparam int BYTE_W      = 8;

  // Overwrite marker " ~ "
  localparam int MARKER_LEN  = 3;
  localparam int MARK_W      = $clog2(MARKER_LEN);

  // Stream word widths
  localparam int IN_DATA_W   = 16;
  localparam int IN_USER_W   = 3;
  localparam int OUT_DATA_W  = 24;

  // Operation codes
  localparam logic [1:0] MODE_INSERT  = 2'd0;
  localparam logic [1:0] MODE_EXTRACT = 2'd1;
  localparam logic [1:0] MODE_ADJUST  = 2'd2;

  // One input word, unpacked
  typedef struct packed {
    logic [1:0]        mode;
    logic [BYTE_W-1:0] data_byte;
    logic [CNT_W-1:0]  length;
    logic              first;
    logic              last;
    logic              overwrite;
  } brb_item_t;

  // One result word
  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic [CNT_W-1:0]  count;
    logic [CNT_W-1:0]  fill_level;
    logic              final_res;
  } brb_res_t;

  // Ring memory access for one cycle
  typedef struct packed {
    logic              we;
    logic [PTR_W-1:0]  waddr;
    logic [BYTE_W-1:0] wdata;
    logic              re;
    logic [PTR_W-1:0]  raddr;
  } brb_ram_req_t;

  // Marker byte by position
  function automatic logic [BYTE_W-1:0] marker_byte(input logic [MARK_W-1:0] idx);
    logic [BYTE_W-1:0] b;
    b = 8'h20;                      // space
    if (idx == MARK_W'(1)) begin
      b = 8'h7E;                    // tilde
    end
    return b;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/brb_ram.sv @@
// ----------------------------------------------------------------------------
// brb_ram
// Ring storage: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module brb_ram
  import brb_pkg::*;
(
  input  wire logic              clk,
  input  wire brb_ram_req_t      req,
  output logic [BYTE_W-1:0]      rdata
);

  logic [BYTE_W-1:0] mem [RING_SIZE];

  // Write port
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/brb_ctrl.sv @@
// ----------------------------------------------------------------------------
// brb_ctrl
// Pointer keeping and sequencing for insert, overwrite marker, extract and
// adjust; drives the ring memory and hands result words to the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module brb_ctrl
  import brb_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  // input words
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire brb_item_t         item,
  // result words
  output logic                   res_valid,
  input  wire logic              res_ready,
  output brb_res_t               res,
  // ring memory
  output brb_ram_req_t           ram_req,
  input  wire logic [BYTE_W-1:0] ram_rdata
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MARK = 4'b0010,
    ST_INS  = 4'b0100,
    ST_EXT  = 4'b1000
  } state_t;

  state_t              state_r, state_nxt;
  logic [PTR_W-1:0]    wp_r, wp_nxt;
  logic [PTR_W-1:0]    rp_r, rp_nxt;
  logic [CNT_W-1:0]    quota_r, quota_nxt;
  logic [CNT_W-1:0]    taken_r, taken_nxt;
  logic [BYTE_W-1:0]   data_r, data_nxt;
  logic                last_r, last_nxt;
  logic [CNT_W-1:0]    lenc_r, lenc_nxt;
  logic [MARK_W-1:0]   mark_r, mark_nxt;
  logic [CNT_W-1:0]    xcnt_r, xcnt_nxt;
  logic [CNT_W-1:0]    rem_r, rem_nxt;

  logic [CNT_W-1:0]    fill;
  logic [CNT_W-1:0]    space;
  logic [CNT_W-1:0]    lenc;
  logic [CNT_W:0]      drop_req;
  logic [CNT_W-1:0]    drop_n;
  logic [CNT_W-1:0]    xfer_n;
  logic [CNT_W-1:0]    adj_n;

  // shared insert-data step
  logic                ins_go;
  logic [CNT_W-1:0]    ins_quota;
  logic [CNT_W-1:0]    ins_taken;
  logic [BYTE_W-1:0]   ins_byte;
  logic                ins_last;
  logic                ins_push;
  logic [CNT_W-1:0]    ins_taken_new;

  // Occupancy from the pointers
  assign fill  = CNT_W'(PTR_W'(wp_r - rp_r));
  assign space = CNT_W'(MAX_LEN) - fill;

  // Length capped to what the ring can ever hold
  assign lenc  = (item.length > CNT_W'(MAX_LEN)) ? CNT_W'(MAX_LEN) : item.length;

  // Overwrite drop: excess plus marker, at most the fill level
  assign drop_req = {1'b0, lenc} - {1'b0, space} + (CNT_W+1)'(MARKER_LEN);
  assign drop_n   = (drop_req > {1'b0, fill}) ? fill : drop_req[CNT_W-1:0];

  // Extract and adjust counts
  always_comb begin
    xfer_n = (item.length > fill) ? fill : item.length;
    if (xfer_n > CNT_W'(MAX_RESULTS)) begin
      xfer_n = CNT_W'(MAX_RESULTS);
    end
  end
  assign adj_n = (item.length > fill) ? fill : item.length;

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    wp_nxt    = wp_r;
    rp_nxt    = rp_r;
    quota_nxt = quota_r;
    taken_nxt = taken_r;
    data_nxt  = data_r;
    last_nxt  = last_r;
    lenc_nxt  = lenc_r;
    mark_nxt  = mark_r;
    xcnt_nxt  = xcnt_r;
    rem_nxt   = rem_r;

    in_ready  = 1'b0;
    res_valid = 1'b0;
    res       = '0;
    ram_req   = '0;

    ins_go    = 1'b0;
    ins_quota = quota_r;
    ins_taken = taken_r;
    ins_byte  = item.data_byte;
    ins_last  = item.last;
    ins_push  = 1'b0;
    ins_taken_new = taken_r;

    unique case (state_r)
      ST_IDLE: begin
        in_ready = res_ready;
        if (in_valid && res_ready) begin
          unique case (item.mode)
            MODE_INSERT: begin
              if (item.first && item.overwrite && (lenc > space)) begin
                // drop newest bytes, then lay down the marker
                wp_nxt    = wp_r - PTR_W'(drop_n);
                data_nxt  = item.data_byte;
                last_nxt  = item.last;
                lenc_nxt  = lenc;
                mark_nxt  = '0;
                state_nxt = ST_MARK;
              end else begin
                ins_go = 1'b1;
                if (item.first) begin
                  ins_quota = (lenc > space) ? space : lenc;
                  ins_taken = '0;
                end
              end
            end
            MODE_EXTRACT: begin
              if (xfer_n == '0) begin
                res_valid      = 1'b1;
                res.fill_level = fill;
                res.final_res  = 1'b1;
              end else begin
                ram_req.re    = 1'b1;
                ram_req.raddr = rp_r;
                xcnt_nxt      = xfer_n;
                rem_nxt       = xfer_n;
                state_nxt     = ST_EXT;
              end
            end
            MODE_ADJUST: begin
              wp_nxt         = wp_r - PTR_W'(adj_n);
              res_valid      = 1'b1;
              res.count      = adj_n;
              res.fill_level = fill - adj_n;
              res.final_res  = 1'b1;
            end
            default: begin
              // reserved code: report state only
              res_valid      = 1'b1;
              res.fill_level = fill;
              res.final_res  = 1'b1;
            end
          endcase
        end
      end

      ST_MARK: begin
        // marker always fits: the drop freed at least its length
        ram_req.we    = 1'b1;
        ram_req.waddr = wp_r;
        ram_req.wdata = marker_byte(mark_r);
        wp_nxt        = wp_r + PTR_W'(1);
        mark_nxt      = mark_r + MARK_W'(1);
        if (mark_r == MARK_W'(MARKER_LEN - 1)) begin
          state_nxt = ST_INS;
        end
      end

      ST_INS: begin
        if (res_ready) begin
          ins_go    = 1'b1;
          ins_quota = (lenc_r > space) ? space : lenc_r;
          ins_taken = '0;
          ins_byte  = data_r;
          ins_last  = last_r;
          state_nxt = ST_IDLE;
        end
      end

      ST_EXT: begin
        res_valid      = 1'b1;
        res.out_byte   = ram_rdata;
        res.count      = xcnt_r;
        res.fill_level = fill - CNT_W'(1);
        res.final_res  = (rem_r == CNT_W'(1));
        if (res_ready) begin
          rp_nxt  = rp_r + PTR_W'(1);
          rem_nxt = rem_r - CNT_W'(1);
          if (rem_r != CNT_W'(1)) begin
            ram_req.re    = 1'b1;
            ram_req.raddr = rp_r + PTR_W'(1);
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Store one data byte of an insert while within its quota and there is space, and report it
    if (ins_go) begin
      ins_push      = (ins_taken < ins_quota) && (space != '0);
      ins_taken_new = ins_taken + CNT_W'(ins_push);
      if (ins_push) begin
        ram_req.we    = 1'b1;
        ram_req.waddr = wp_r;
        ram_req.wdata = ins_byte;
        wp_nxt        = wp_r + PTR_W'(1);
      end
      res_valid      = 1'b1;
      res.count      = ins_taken_new;
      res.fill_level = fill + CNT_W'(ins_push);
      res.final_res  = 1'b1;
      if (ins_last) begin
        quota_nxt = '0;
        taken_nxt = '0;
      end else begin
        quota_nxt = ins_quota;
        taken_nxt = ins_taken_new;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      wp_r    <= '0;
      rp_r    <= '0;
      quota_r <= '0;
      taken_r <= '0;
      mark_r  <= '0;
      rem_r   <= '0;
    end else begin
      state_r <= state_nxt;
      wp_r    <= wp_nxt;
      rp_r    <= rp_nxt;
      quota_r <= quota_nxt;
      taken_r <= taken_nxt;
      mark_r  <= mark_nxt;
      rem_r   <= rem_nxt;
    end
  end

  // Held item fields
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    last_r <= last_nxt;
    lenc_r <= lenc_nxt;
    xcnt_r <= xcnt_nxt;
  end

endmodule

`default_nettype wire

@@ rtl/core/byte_ring_buffer_with_overwrite.sv @@
// ----------------------------------------------------------------------------
// byte_ring_buffer_with_overwrite
// Byte ring FIFO with optional overwrite of the newest data, stream ports.
// ----------------------------------------------------------------------------
// A 64-byte ring holding at most 63 bytes. An insert byte (mode 0) returns one
// word; a first byte with overwrite set on a ring too full for its length goes
// through the drop, three marker writes and the data write, in that order, all
// through the single write port of the ring memory.
// An extract (mode 1) returns its bytes one word per cycle while the output
// register takes them, after a registered read; an adjust (mode 2) returns
// one word. A new word is taken only when the output register is empty or is
// drained in the same cycle, so a waiting result stalls the input. Every
// result word carries the fill level after it.
`default_nettype none

module byte_ring_buffer_with_overwrite
  import brb_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // input stream
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // data_byte, length, overwrite
  input  wire logic [IN_USER_W-1:0]  in_tuser,   // mode, first
  input  wire logic                  in_tlast,
  // result stream
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,  // out_byte, count, fill_level, pad
  output logic                       out_tlast   // final_res
);

  brb_item_t         item;
  brb_res_t          res;
  logic              res_valid;
  logic              res_ready;
  brb_ram_req_t      ram_req;
  logic [BYTE_W-1:0] ram_rdata;

  logic              out_valid_r;
  brb_res_t          out_res_r;

  // Unpack the input word
  always_comb begin
    item.mode      = in_tuser[1:0];
    item.first     = in_tuser[2];
    item.data_byte = in_tdata[BYTE_W-1:0];
    item.length    = in_tdata[BYTE_W +: CNT_W];
    item.overwrite = in_tdata[BYTE_W + CNT_W];
    item.last      = in_tlast;
  end

  brb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .item      (item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata)
  );

  brb_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

  // Output register
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_res_r.final_res;
  assign out_tdata  = {(OUT_DATA_W - BYTE_W - 2*CNT_W)'(0),
                       out_res_r.fill_level, out_res_r.count, out_res_r.out_byte};

endmodule

`default_nettype wire

@@ verif/tb_byte_ring_buffer_with_overwrite.sv @@
// ----------------------------------------------------------------------------
// tb_byte_ring_buffer_with_overwrite
// Self-checking bench: a directed table, then random insert, extract and
// adjust traffic under three idle patterns. Every accepted input word runs
// through a ring model; its results or a typed row's are checked field by field.
// ----------------------------------------------------------------------------
module tb_byte_ring_buffer_with_overwrite;
  import brb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0]        MODE_UNUSED = 2'd3;
  localparam logic [BYTE_W-1:0] MARK_SPACE  = 8'h20;
  localparam logic [BYTE_W-1:0] MARK_TILDE  = 8'h7E;
  localparam int                RAND_ITEMS  = 470;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;   // data_byte, length, overwrite
  logic [IN_USER_W-1:0]  in_tuser = '0;   // mode, first
  logic                  in_tlast = 1'b0; // last
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;       // out_byte, count, fill_level, pad
  logic                  out_tlast;       // final_res

  byte_ring_buffer_with_overwrite dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Directed rows; typed rows always expect out_byte 0 and final_res 1
  typedef struct packed {
    brb_item_t        it;
    logic             typed;
    logic [CNT_W-1:0] exp_count;
    logic [CNT_W-1:0] exp_fill;
  } dir_row_t;

  localparam int N_DIR = 22;
  localparam dir_row_t DIRECTED [N_DIR] = '{
    // empty ring: extract, adjust, unknown mode, stray insert byte
    '{'{MODE_EXTRACT, 8'h00, 7'd5,   1'b0, 1'b0, 1'b0}, 1'b1, 7'd0, 7'd0},
    '{'{MODE_ADJUST,  8'h00, 7'd127, 1'b0, 1'b0, 1'b0}, 1'b1, 7'd0, 7'd0},
    '{'{MODE_UNUSED,  8'hFF, 7'd9,   1'b1, 1'b1, 1'b1}, 1'b1, 7'd0, 7'd0},
    '{'{MODE_INSERT,  8'hAA, 7'd4,   1'b0, 1'b0, 1'b0}, 1'b1, 7'd0, 7'd0},
    // length capped to the most the ring holds, three bytes
    '{'{MODE_INSERT,  8'h00, 7'd127, 1'b1, 1'b0, 1'b0}, 1'b1, 7'd1, 7'd1},
    '{'{MODE_INSERT,  8'hFF, 7'd0,   1'b0, 1'b0, 1'b0}, 1'b1, 7'd2, 7'd2},
    '{'{MODE_INSERT,  8'h5A, 7'd0,   1'b0, 1'b1, 1'b0}, 1'b1, 7'd3, 7'd3},
    // bytes past the declared length are dropped
    '{'{MODE_INSERT,  8'h11, 7'd2,   1'b1, 1'b0, 1'b0}, 1'b0, 7'd0, 7'd0},
    '{'{MODE_INSERT,  8'h22, 7'd0,   1'b0, 1'b0, 1'b0}, 1'b0, 7'd0, 7'd0},
    '{'{MODE_INSERT,  8'h33, 7'd0,   1'b0, 1'b0, 1'b0}, 1'b0, 7'd0, 7'd0},
    '{'{MODE_INSERT,  8'h44, 7'd0,   1'b0, 1'b1, 1'b0}, 1'b0, 7'd0, 7'd0},
    // overwrite: drop newest, marker, then data
    '{'{MODE_INSERT,  8'h80, 7'd63,  1'b1, 1'b0, 1'b1}, 1'b0, 7'd0, 7'd0},
    '{'{MODE_INSERT,  8'h7F, 7'd0,   1'b0, 1'b1, 1'b0}, 1'b0, 7'd0, 7'd0},
    '{'{MODE_EXTRACT, 8'h00, 7'd127, 1'b0, 1'b0, 1'b0}, 1'b0, 7'd0, 7'd0},
    // single byte insert, then a truncated one
    '{'{MODE_INSERT,  8'hC3, 7'd1,   1'b1, 1'b1, 1'b0}, 1'b0, 7'd0, 7'd0},
    '{'{MODE_INSERT,  8'h01, 7'd63,  1'b1, 1'b0, 1'b0}, 1'b0, 7'd0, 7'd0},
    '{'{MODE_INSERT,  8'h02, 7'd0,   1'b0, 1'b1, 1'b0}, 1'b0, 7'd0, 7'd0},
    '{'{MODE_ADJUST,  8'h00, 7'd1,   1'b0, 1'b0, 1'b0}, 1'b0, 7'd0, 7'd0},
    '{'{MODE_EXTRACT, 8'h00, 7'd0,   1'b0, 1'b0, 1'b0}, 1'b0, 7'd0, 7'd0},
    '{'{MODE_EXTRACT, 8'h00, 7'd1,   1'b0, 1'b0, 1'b0}, 1'b0, 7'd0, 7'd0},
    '{'{MODE_ADJUST,  8'h00, 7'd127, 1'b0, 1'b0, 1'b0}, 1'b0, 7'd0, 7'd0},
    // zero-length insert takes nothing
    '{'{MODE_INSERT,  8'hEE, 7'd0,   1'b1, 1'b1, 1'b1}, 1'b0, 7'd0, 7'd0}
  };

  // Ring model state
  logic [BYTE_W-1:0] ring_mem [RING_SIZE];
  logic [PTR_W-1:0]  wr_ptr = '0;
  logic [PTR_W-1:0]  rd_ptr = '0;
  int unsigned       quota = 0;
  int unsigned       taken = 0;

  brb_res_t ring_out [$];     // results of the word just modeled
  brb_res_t pending_res [$];  // results still owed by the block

  int err_count = 0;
  int items_done = 0;
  int src_idle_pct = 31;
  int snk_idle_pct = 80;

  function automatic int unsigned ring_fill();
    logic [PTR_W-1:0] d;
    d = wr_ptr - rd_ptr;
    return d;
  endfunction

  function automatic int unsigned ring_space();
    return MAX_LEN - ring_fill();
  endfunction

  function automatic void push_ring(logic [BYTE_W-1:0] b);
    if (ring_space() > 0) begin
      ring_mem[wr_ptr] = b;
      wr_ptr = wr_ptr + 1'b1;
    end
  endfunction

  function automatic int unsigned drop_newest(int unsigned n);
    int unsigned g;
    g = ring_fill();
    if (n > g) n = g;
    wr_ptr = wr_ptr - PTR_W'(n);
    return n;
  endfunction

  function automatic void emit(logic [BYTE_W-1:0] b, int unsigned cnt, bit fin);
    brb_res_t r;
    r.out_byte   = b;
    r.count      = CNT_W'(cnt);
    r.fill_level = CNT_W'(ring_fill());
    r.final_res  = fin;
    ring_out.push_back(r);
  endfunction

  // Advance the ring model by one accepted word, results into ring_out
  function automatic void predict_ring(brb_item_t it);
    int unsigned len;
    int unsigned sp;
    int unsigned n;
    ring_out.delete();
    len = it.length;
    case (it.mode)
      MODE_INSERT: begin
        if (it.first) begin
          sp = ring_space();
          if (len > MAX_LEN) len = MAX_LEN;
          if (len > sp) begin
            if (it.overwrite) begin
              void'(drop_newest(len - sp + MARKER_LEN));
              push_ring(MARK_SPACE);
              push_ring(MARK_TILDE);
              push_ring(MARK_SPACE);
              sp = ring_space();
              if (len > sp) len = sp;
            end else begin
              len = sp;
            end
          end
          quota = len;
          taken = 0;
        end
        if (taken < quota && ring_space() > 0) begin
          push_ring(it.data_byte);
          taken = (taken + 1) & 7'h7F;
        end
        n = taken;
        if (it.last) begin
          quota = 0;
          taken = 0;
        end
        emit('0, n, 1'b1);
      end
      MODE_EXTRACT: begin
        n = len;
        if (n > ring_fill()) n = ring_fill();
        if (n > MAX_RESULTS) n = MAX_RESULTS;
        if (n == 0) begin
          emit('0, 0, 1'b1);
        end else begin
          for (int unsigned k = 0; k < n; k++) begin
            logic [BYTE_W-1:0] b;
            b = ring_mem[rd_ptr];
            rd_ptr = rd_ptr + 1'b1;
            emit(b, n, k + 1 == n);
          end
        end
      end
      MODE_ADJUST: begin
        n = drop_newest(len);
        emit('0, n, 1'b1);
      end
      default: begin
        emit('0, 0, 1'b1);
      end
    endcase
  endfunction

  // Drive one word, wait for the handshake, then book its results
  task automatic send_word(brb_item_t it, bit typed = 1'b0,
                           logic [CNT_W-1:0] t_count = '0,
                           logic [CNT_W-1:0] t_fill = '0);
    brb_res_t r;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {it.overwrite, it.length, it.data_byte};
    in_tuser  <= {it.first, it.mode};
    in_tlast  <= it.last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_ring(it);
    if (typed) begin
      r.out_byte   = '0;
      r.count      = t_count;
      r.fill_level = t_fill;
      r.final_res  = 1'b1;
      pending_res.push_back(r);
    end else begin
      foreach (ring_out[i]) pending_res.push_back(ring_out[i]);
    end
    items_done++;
  endtask

  // One insert run; broken runs miss bytes, add bytes or lose the last flag
  task automatic send_insert_run();
    brb_item_t it;
    int unsigned len;
    int unsigned nbytes;
    bit broken;
    bit no_last;
    case ($urandom_range(0, 15))
      0:       len = 0;
      1, 2:    len = $urandom_range(25, 127);
      default: len = $urandom_range(1, 24);
    endcase
    broken  = ($urandom_range(0, 9) == 0);
    nbytes  = len > 70 ? 70 : len;
    no_last = 1'b0;
    if (broken) begin
      nbytes  = $urandom_range(0, nbytes + 3);
      no_last = 1'($urandom_range(0, 1));
    end
    if (nbytes == 0) nbytes = 1;
    for (int unsigned k = 0; k < nbytes; k++) begin
      it.mode      = MODE_INSERT;
      it.data_byte = BYTE_W'($urandom());
      it.length    = (k == 0) ? CNT_W'(len) : CNT_W'($urandom());
      it.first     = (k == 0);
      it.last      = (k + 1 == nbytes) && !no_last;
      it.overwrite = 1'($urandom_range(0, 1));
      send_word(it);
    end
  endtask

  // Random traffic until the word count reaches the target
  task automatic run_random(int target);
    brb_item_t it;
    int pick;
    while (items_done < target) begin
      pick = $urandom_range(0, 99);
      it = brb_item_t'($urandom());
      if (pick < 50) begin
        send_insert_run();
      end else if (pick < 72) begin
        it.mode   = MODE_EXTRACT;
        it.length = ($urandom_range(0, 9) < 7) ? CNT_W'($urandom_range(1, 16))
                                               : CNT_W'($urandom());
        send_word(it);
      end else if (pick < 84) begin
        it.mode   = MODE_ADJUST;
        it.length = ($urandom_range(0, 3) != 0) ? CNT_W'($urandom_range(0, 8))
                                                : CNT_W'($urandom());
        send_word(it);
      end else if (pick < 88) begin
        it.mode = MODE_UNUSED;
        send_word(it);
      end else begin
        // fully random word
        send_word(it);
      end
    end
  endtask

  // Receiver backpressure
  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
  end

  // Result checker
  always @(posedge clk) begin
    brb_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_res.size() == 0) begin
        $error("unexpected result word %h", out_tdata);
        err_count++;
      end else begin
        want = pending_res.pop_front();
        if (out_tdata[7:0] !== want.out_byte) begin
          $error("out_byte exp %0h got %0h", want.out_byte, out_tdata[7:0]);
          err_count++;
        end
        if (out_tdata[14:8] !== want.count) begin
          $error("count exp %0d got %0d", want.count, out_tdata[14:8]);
          err_count++;
        end
        if (out_tdata[21:15] !== want.fill_level) begin
          $error("fill_level exp %0d got %0d", want.fill_level, out_tdata[21:15]);
          err_count++;
        end
        if (out_tlast !== want.final_res) begin
          $error("final_res exp %0b got %0b", want.final_res, out_tlast);
          err_count++;
        end
      end
    end
  end

  // Main sequence
  initial begin
    int guard;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_DIR; i++) begin
      send_word(DIRECTED[i].it, DIRECTED[i].typed,
                DIRECTED[i].exp_count, DIRECTED[i].exp_fill);
    end

    items_done = 0;
    run_random(RAND_ITEMS / 3);
    src_idle_pct = 80;
    snk_idle_pct = 31;
    run_random(2 * RAND_ITEMS / 3);
    src_idle_pct = 0;
    snk_idle_pct = 0;
    run_random(RAND_ITEMS);

    in_tvalid <= 1'b0;
    guard = 0;
    while (pending_res.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (16) @(posedge clk);
    if (pending_res.size() != 0) begin
      $error("%0d result words never arrived", pending_res.size());
      err_count++;
    end

    if (err_count == 0) begin
      $display("[byte_ring_buffer_with_overwrite] OK");
    end else begin
      $display("[byte_ring_buffer_with_overwrite] ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("[byte_ring_buffer_with_overwrite] ERROR");
    $finish;
  end

endmodule
